FILE: rtl/core/acc_pkg.sv
`timescale 1ns / 1ps
package acc_pkg;

   localparam int NUM_BUTTONS = 8;

   localparam logic [15:0] TICKS_RESET  = 16'd128;
   localparam logic [7:0]  SNOOZE_RESET = 8'd10;
   localparam logic [16:0] DAY_SECONDS  = 17'd86400;
   localparam logic [16:0] CLOCK_RESET  = 17'd3590;
   localparam logic [16:0] ALARM_RESET  = 17'd3600;
   localparam logic [16:0] MIN_SECONDS  = 17'd60;
   localparam logic [16:0] HOUR_SECONDS = 17'd3600;

   localparam logic [15:0] HIST_MASK    = 16'hE000;
   localparam logic [15:0] HIST_PRESSED = 16'hF000;

   // configuration register indexes
   localparam logic CSR_TICKS  = 1'b0;
   localparam logic CSR_SNOOZE = 1'b1;

   // button roles
   localparam int BTN_SET_ALARM = 0;
   localparam int BTN_SET_TIME  = 1;
   localparam int BTN_SOUND     = 2;
   localparam int BTN_ARM       = 3;
   localparam int BTN_SNOOZE    = 4;
   localparam int BTN_TWELVE    = 7;

   // mode flag bits
   localparam int F_COLON   = 0;
   localparam int F_SETTIME = 1;
   localparam int F_SETALRM = 2;
   localparam int F_TWELVE  = 3;
   localparam int F_ARMED   = 4;
   localparam int F_SOUND   = 5;
   localparam int F_PLAYED  = 6;
   localparam logic [6:0] FLAGS_RESET = 7'b0000001;

   localparam logic [2:0] STEPS_CENTER = 3'd4;
   localparam logic [2:0] STEPS_UP     = 3'd7;
   localparam logic [2:0] STEPS_DOWN   = 3'd1;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_UP   = 2'd2;

   localparam logic [1:0] PHASE_ORDER [4] = '{2'd3, 2'd1, 2'd0, 2'd2};

   // reciprocal constants: t/60 and t/3600 exact for t < 86400
   localparam logic [17:0] DIV60_MUL     = 18'd139811;
   localparam int          DIV60_SHIFT   = 23;
   localparam logic [16:0] DIV3600_MUL   = 17'd74566;
   localparam int          DIV3600_SHIFT = 28;

   typedef struct packed {
      logic [7:0] buttons_raw;
      logic [3:0] knob_phases;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] display_hhmm;
      logic        colon_on;
      logic        setting_time;
      logic        setting_alarm;
      logic        twelve_hour;
      logic        alarm_armed;
      logic        sound_on;
      logic        snoozing;
   } rsp_payload_type;

   typedef struct packed {
      logic [16:0] shown;
      logic        colon_on;
      logic        setting_time;
      logic        setting_alarm;
      logic        twelve_hour;
      logic        alarm_armed;
      logic        sound_on;
      logic        snoozing;
   } snap_type;

   function automatic logic [16:0] wrap_add(logic [16:0] t, logic [16:0] d);
      logic [17:0] sum;
      sum = {1'b0, t} + {1'b0, d};
      if (sum >= {1'b0, DAY_SECONDS}) begin
         sum = sum - {1'b0, DAY_SECONDS};
      end
      return sum[16:0];
   endfunction

   function automatic logic [1:0] knob_dir(logic [1:0] old_ph, logic [1:0] now_ph);
      logic [1:0] p;
      logic [1:0] dir;
      p = 2'd0;
      dir = DIR_NONE;
      for (int i = 0; i < 4; i++) begin
         if (PHASE_ORDER[i] == now_ph) begin
            p = 2'(i);
         end
      end
      if (old_ph != now_ph) begin
         if (old_ph == PHASE_ORDER[p - 2'd1]) begin
            dir = DIR_DOWN;
         end else if (old_ph == PHASE_ORDER[p + 2'd1]) begin
            dir = DIR_UP;
         end
      end
      return dir;
   endfunction

endpackage

FILE: rtl/core/acc_stream_if.sv
`timescale 1ns / 1ps
interface acc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/acc_state.sv
`timescale 1ns / 1ps
module acc_state (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  acc_pkg::req_payload_type req_data,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [15:0]              csr_wdata,
   output acc_pkg::snap_type        snap
);
   import acc_pkg::*;

   logic [15:0] tps_ff;
   logic [7:0]  snz_secs_ff;
   logic [15:0] hist_ff [NUM_BUTTONS];
   logic [15:0] hist_in [NUM_BUTTONS];
   logic [15:0] tick_ff, tick_in;
   logic [16:0] clock_ff, clock_in;
   logic [16:0] alarm_ff, alarm_in;
   logic [6:0]  flags_ff, flags_in;
   logic [7:0]  snooze_ff, snooze_in;
   logic [1:0]  kprev_ff [2];
   logic [1:0]  kprev_in [2];
   logic [2:0]  ksteps_ff [2];
   logic [2:0]  ksteps_in [2];
   logic [NUM_BUTTONS-1:0] pulse;
   logic [1:0]  dir;
   logic [2:0]  st;
   logic [16:0] delta;

   always_comb begin
      flags_in  = flags_ff;
      tick_in   = tick_ff;
      clock_in  = clock_ff;
      alarm_in  = alarm_ff;
      snooze_in = snooze_ff;
      dir       = DIR_NONE;
      st        = STEPS_CENTER;
      delta     = '0;

      if (tick_in == (tps_ff >> 1)) flags_in[F_COLON] = 1'b0;
      if (tick_in >= tps_ff) begin
         flags_in[F_COLON] = 1'b1;
         tick_in = '0;
         clock_in = wrap_add(clock_in, 17'd1);
         if (snooze_in != 8'd0) begin
            flags_in[F_SOUND] = 1'b0;
            snooze_in = snooze_in - 8'd1;
            if (snooze_in == 8'd0 && flags_in[F_ARMED]) begin
               flags_in[F_SOUND]  = 1'b1;
               flags_in[F_PLAYED] = 1'b1;
            end
         end
      end
      tick_in = tick_in + 16'd1;
      if (flags_in[F_SETTIME] || flags_in[F_SETALRM]) flags_in[F_COLON] = 1'b1;

      for (int b = 0; b < NUM_BUTTONS; b++) begin
         hist_in[b] = {hist_ff[b][14:0], req_data.buttons_raw[b]} | HIST_MASK;
         pulse[b]   = (hist_in[b] == HIST_PRESSED);
      end

      if (pulse[BTN_SET_ALARM] && !flags_in[F_SETTIME]) flags_in[F_SETALRM] = !flags_in[F_SETALRM];
      if (pulse[BTN_SET_TIME] && !flags_in[F_SETALRM]) flags_in[F_SETTIME] = !flags_in[F_SETTIME];
      if (pulse[BTN_SOUND]) flags_in[F_SOUND] = !flags_in[F_SOUND];
      if (pulse[BTN_ARM]) begin
         flags_in[F_ARMED] = !flags_in[F_ARMED];
         if (!flags_in[F_ARMED]) flags_in[F_SOUND] = 1'b0;
      end
      if (pulse[BTN_SNOOZE] && flags_in[F_PLAYED] && flags_in[F_ARMED]) begin
         snooze_in = snz_secs_ff;
      end
      if (pulse[BTN_TWELVE]) flags_in[F_TWELVE] = !flags_in[F_TWELVE];

      for (int k = 0; k < 2; k++) begin
         kprev_in[k] = req_data.knob_phases[2*k +: 2];
         dir = knob_dir(kprev_ff[k], kprev_in[k]);
         st  = ksteps_ff[k];
         if (dir == DIR_DOWN) begin
            st = st - 3'd1;
         end else if (dir == DIR_UP) begin
            st = st + 3'd1;
         end
         // minute knob first, then hour knob
         delta = '0;
         if (st == STEPS_UP) begin
            st = STEPS_CENTER;
            delta = (k == 0) ? MIN_SECONDS : HOUR_SECONDS;
         end else if (st == STEPS_DOWN) begin
            st = STEPS_CENTER;
            delta = DAY_SECONDS - ((k == 0) ? MIN_SECONDS : HOUR_SECONDS);
         end
         if (delta != '0) begin
            if (flags_in[F_SETTIME]) clock_in = wrap_add(clock_in, delta);
            if (flags_in[F_SETALRM]) alarm_in = wrap_add(alarm_in, delta);
         end
         ksteps_in[k] = st;
      end

      if (flags_in[F_ARMED] && clock_in == alarm_in) begin
         flags_in[F_SOUND]  = 1'b1;
         flags_in[F_PLAYED] = 1'b1;
      end
   end

   always_comb begin
      snap.shown         = flags_in[F_SETALRM] ? alarm_in : clock_in;
      snap.colon_on      = flags_in[F_COLON];
      snap.setting_time  = flags_in[F_SETTIME];
      snap.setting_alarm = flags_in[F_SETALRM];
      snap.twelve_hour   = flags_in[F_TWELVE];
      snap.alarm_armed   = flags_in[F_ARMED];
      snap.sound_on      = flags_in[F_SOUND];
      snap.snoozing      = (snooze_in != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff      <= TICKS_RESET;
         snz_secs_ff <= SNOOZE_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_TICKS) tps_ff <= csr_wdata;
         if (csr_index == CSR_SNOOZE) snz_secs_ff <= csr_wdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BUTTONS; b++) hist_ff[b] <= '0;
         tick_ff   <= '0;
         clock_ff  <= CLOCK_RESET;
         alarm_ff  <= ALARM_RESET;
         flags_ff  <= FLAGS_RESET;
         snooze_ff <= '0;
         for (int k = 0; k < 2; k++) begin
            kprev_ff[k]  <= '0;
            ksteps_ff[k] <= STEPS_CENTER;
         end
      end else if (accept) begin
         for (int b = 0; b < NUM_BUTTONS; b++) hist_ff[b] <= hist_in[b];
         tick_ff   <= tick_in;
         clock_ff  <= clock_in;
         alarm_ff  <= alarm_in;
         flags_ff  <= flags_in;
         snooze_ff <= snooze_in;
         for (int k = 0; k < 2; k++) begin
            kprev_ff[k]  <= kprev_in[k];
            ksteps_ff[k] <= ksteps_in[k];
         end
      end
   end

   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      clock_ff < DAY_SECONDS && alarm_ff < DAY_SECONDS) else $error("time out of day range");
   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(flags_ff[F_SETTIME] && flags_ff[F_SETALRM])) else $error("both set modes active");
   a_steps_range: assert property (@(posedge clock) disable iff (reset)
      ksteps_ff[0] >= 3'd2 && ksteps_ff[0] <= 3'd6 && ksteps_ff[1] >= 3'd2 && ksteps_ff[1] <= 3'd6)
      else $error("knob step count escaped");
endmodule

FILE: rtl/core/acc_disp.sv
`timescale 1ns / 1ps
module acc_disp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  acc_pkg::snap_type        in_snap,
   output logic                     out_valid,
   input  logic                     out_ready,
   output acc_pkg::rsp_payload_type out_data
);
   import acc_pkg::*;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic        s1_ready, s2_ready, s3_ready;
   snap_type    s1_ff, s2_ff;
   logic [34:0] prod_min;
   logic [33:0] prod_hr;
   logic [10:0] mins_ff;
   logic [4:0]  hrs_ff;
   logic [10:0] hrs_x60;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [11:0] hhmm_in;
   rsp_payload_type out_ff;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign prod_min = {18'd0, s1_ff.shown} * {17'd0, DIV60_MUL};
   assign prod_hr  = {17'd0, s1_ff.shown} * {17'd0, DIV3600_MUL};

   always_comb begin
      hrs_x60 = ({6'd0, hrs_ff} << 6) - ({6'd0, hrs_ff} << 2);
      minute  = 6'(mins_ff - hrs_x60);
      hour    = hrs_ff;
      if (s2_ff.twelve_hour) begin
         if (hour >= 5'd12) hour = hour - 5'd12;
         if (hour == 5'd0) hour = 5'd12;
      end
      hhmm_in = {6'd0, minute} + ({7'd0, hour} << 6) + ({7'd0, hour} << 5)
              + ({7'd0, hour} << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= in_snap;
      if (s2_ready && s1_valid_ff) begin
         s2_ff   <= s1_ff;
         mins_ff <= prod_min[DIV60_SHIFT +: 11];
         hrs_ff  <= prod_hr[DIV3600_SHIFT +: 5];
      end
      if (s3_ready && s2_valid_ff) begin
         out_ff.display_hhmm  <= hhmm_in;
         out_ff.colon_on      <= s2_ff.colon_on;
         out_ff.setting_time  <= s2_ff.setting_time;
         out_ff.setting_alarm <= s2_ff.setting_alarm;
         out_ff.twelve_hour   <= s2_ff.twelve_hour;
         out_ff.alarm_armed   <= s2_ff.alarm_armed;
         out_ff.sound_on      <= s2_ff.sound_on;
         out_ff.snoozing      <= s2_ff.snoozing;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = out_ff;

   a_hours_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> hrs_ff < 5'd24) else $error("hour out of range");
   a_minute_split: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (mins_ff >= hrs_x60 && mins_ff - hrs_x60 < 11'd60))
      else $error("minute split inconsistent");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_ready |=> s3_valid_ff && $stable(out_ff))
      else $error("stalled item changed");
endmodule

FILE: rtl/core/alarm_clock_controller_top.sv
`timescale 1ns / 1ps
// Alarm clock controller. Each accepted req item is one timer tick carrying
// the raw active-low buttons and both knob phases; each tick yields exactly one
// rsp item with the shown HHMM, the colon and the mode flags. A tick is taken
// every cycle unless rsp back-pressure stalls it; state is updated in the
// accepting cycle; HHMM conversion runs in a three-register pipeline (snapshot,
// reciprocal divide by 60 and 3600, digit assembly). Configuration writes go
// through csr_we/csr_index/csr_wdata while idle, which only the user ensures.
module alarm_clock_controller_top (
   input  logic        clock,
   input  logic        reset,
   acc_stream_if.sink   req,
   acc_stream_if.source rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import acc_pkg::*;

   logic     accept;
   snap_type snap;

   assign accept = req.valid && req.ready;

   acc_state u_state (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req.payload),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .snap      (snap)
   );

   acc_disp u_disp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_snap   (snap),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp.payload)
   );
endmodule

FILE: tb/sv/tb_alarm_clock_controller_top.sv
`timescale 1ns / 1ps
module tb_alarm_clock_controller_top;
   import acc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   acc_stream_if #(.payload_type(req_payload_type)) req_ch ();
   acc_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   alarm_clock_controller_top dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predicted clock state
   logic [15:0] ticks_per_sec;
   logic [7:0]  snooze_secs;
   logic [15:0] btn_hist [NUM_BUTTONS];
   logic [15:0] tick_cnt;
   logic [16:0] clock_secs;
   logic [16:0] alarm_secs;
   logic [6:0]  flags;
   logic [7:0]  snooze_cnt;
   logic [1:0]  knob_prev [2];
   logic [2:0]  knob_cnt [2];

   rsp_payload_type expected_displays [$];
   int errors = 0;
   bit hold_off = 1'b0;
   bit idle_gaps = 1'b1;

   function automatic logic [16:0] add_day(logic [16:0] t, logic [16:0] d);
      int unsigned s;
      s = (int'(t) + int'(d)) % 86400;
      return s[16:0];
   endfunction

   function automatic int step_dir(logic [1:0] old_ph, logic [1:0] now_ph);
      int p;
      logic [1:0] seq [4];
      seq = '{2'd3, 2'd1, 2'd0, 2'd2};
      p = 0;
      if (old_ph == now_ph) return 0;
      for (int i = 0; i < 4; i++) if (seq[i] == now_ph) p = i;
      if (old_ph == seq[(p + 3) % 4]) return -1;
      if (old_ph == seq[(p + 1) % 4]) return 1;
      return 0;
   endfunction

   task automatic clock_reset_state();
      ticks_per_sec = TICKS_RESET;
      snooze_secs = SNOOZE_RESET;
      foreach (btn_hist[i]) btn_hist[i] = '0;
      tick_cnt = '0;
      clock_secs = CLOCK_RESET;
      alarm_secs = ALARM_RESET;
      flags = FLAGS_RESET;
      snooze_cnt = '0;
      knob_prev[0] = '0; knob_prev[1] = '0;
      knob_cnt[0] = STEPS_CENTER; knob_cnt[1] = STEPS_CENTER;
   endtask

   task automatic move_setting(logic [16:0] delta);
      if (flags[F_SETTIME]) clock_secs = add_day(clock_secs, delta);
      if (flags[F_SETALRM]) alarm_secs = add_day(alarm_secs, delta);
   endtask

   function automatic logic [11:0] hhmm_of(logic [16:0] t, logic twelve);
      int m, h;
      m = int'(t) / 60;
      h = m / 60;
      if (twelve) begin
         h = h % 12;
         if (h == 0) h = 12;
      end else begin
         h = h % 24;
      end
      return 12'((m % 60) + 100 * h);
   endfunction

   task automatic predict_tick(req_payload_type it);
      logic pr [NUM_BUTTONS];
      rsp_payload_type r;
      int d;
      logic [16:0] unit;
      if (tick_cnt == ticks_per_sec / 2) flags[F_COLON] = 1'b0;
      if (tick_cnt >= ticks_per_sec) begin
         flags[F_COLON] = 1'b1;
         tick_cnt = '0;
         clock_secs = add_day(clock_secs, 17'd1);
         if (snooze_cnt > 0) begin
            flags[F_SOUND] = 1'b0;
            snooze_cnt--;
            if (snooze_cnt == 0 && flags[F_ARMED]) begin
               flags[F_SOUND] = 1'b1; flags[F_PLAYED] = 1'b1;
            end
         end
      end
      tick_cnt++;
      if (flags[F_SETTIME] || flags[F_SETALRM]) flags[F_COLON] = 1'b1;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         btn_hist[i] = (btn_hist[i] << 1) | 16'(it.buttons_raw[i]) | HIST_MASK;
         pr[i] = (btn_hist[i] == HIST_PRESSED);
      end
      if (pr[BTN_SET_ALARM] && !flags[F_SETTIME]) flags[F_SETALRM] ^= 1'b1;
      if (pr[BTN_SET_TIME] && !flags[F_SETALRM]) flags[F_SETTIME] ^= 1'b1;
      if (pr[BTN_SOUND]) flags[F_SOUND] ^= 1'b1;
      if (pr[BTN_ARM]) begin
         flags[F_ARMED] ^= 1'b1;
         if (!flags[F_ARMED]) flags[F_SOUND] = 1'b0;
      end
      if (pr[BTN_SNOOZE] && flags[F_PLAYED] && flags[F_ARMED]) snooze_cnt = snooze_secs;
      if (pr[BTN_TWELVE]) flags[F_TWELVE] ^= 1'b1;
      for (int k = 0; k < 2; k++) begin
         d = step_dir(knob_prev[k], it.knob_phases[2*k +: 2]);
         knob_cnt[k] = 3'(int'(knob_cnt[k]) + d);
         knob_prev[k] = it.knob_phases[2*k +: 2];
      end
      for (int k = 0; k < 2; k++) begin
         unit = (k == 0) ? MIN_SECONDS : HOUR_SECONDS;
         if (knob_cnt[k] == STEPS_UP) begin
            knob_cnt[k] = STEPS_CENTER; move_setting(unit);
         end
         if (knob_cnt[k] == STEPS_DOWN) begin
            knob_cnt[k] = STEPS_CENTER; move_setting(DAY_SECONDS - unit);
         end
      end
      if (flags[F_ARMED] && clock_secs == alarm_secs) begin
         flags[F_SOUND] = 1'b1; flags[F_PLAYED] = 1'b1;
      end
      r.display_hhmm = hhmm_of(flags[F_SETALRM] ? alarm_secs : clock_secs, flags[F_TWELVE]);
      r.colon_on = flags[F_COLON];
      r.setting_time = flags[F_SETTIME];
      r.setting_alarm = flags[F_SETALRM];
      r.twelve_hour = flags[F_TWELVE];
      r.alarm_armed = flags[F_ARMED];
      r.sound_on = flags[F_SOUND];
      r.snoozing = (snooze_cnt != 0);
      expected_displays.push_back(r);
   endtask

   // sender: bursts with random gaps
   int burst_left = 0;
   task automatic send_tick(logic [7:0] btn, logic [3:0] ph);
      req_payload_type it;
      int gap;
      it.buttons_raw = btn;
      it.knob_phases = ph;
      if (idle_gaps && burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_tick(it);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      stop_sending();
      while (expected_displays.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TICKS) ticks_per_sec = val;
      else snooze_secs = val[7:0];
   endtask

   // receiver stall pattern
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_off) rsp_ch.ready <= 1'b0;
      else if (stall_phase[8]) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      rsp_payload_type e, a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.payload;
         if (expected_displays.size() == 0) begin
            $error("unexpected item %h", a);
            errors++;
         end else begin
            e = expected_displays.pop_front();
            if (a.display_hhmm !== e.display_hhmm) begin
               $error("display_hhmm exp %0d got %0d", e.display_hhmm, a.display_hhmm); errors++;
            end
            if (a.colon_on !== e.colon_on) begin
               $error("colon_on exp %0b got %0b", e.colon_on, a.colon_on); errors++;
            end
            if (a.setting_time !== e.setting_time) begin
               $error("setting_time exp %0b got %0b", e.setting_time, a.setting_time); errors++;
            end
            if (a.setting_alarm !== e.setting_alarm) begin
               $error("setting_alarm exp %0b got %0b", e.setting_alarm, a.setting_alarm);
               errors++;
            end
            if (a.twelve_hour !== e.twelve_hour) begin
               $error("twelve_hour exp %0b got %0b", e.twelve_hour, a.twelve_hour); errors++;
            end
            if (a.alarm_armed !== e.alarm_armed) begin
               $error("alarm_armed exp %0b got %0b", e.alarm_armed, a.alarm_armed); errors++;
            end
            if (a.sound_on !== e.sound_on) begin
               $error("sound_on exp %0b got %0b", e.sound_on, a.sound_on); errors++;
            end
            if (a.snoozing !== e.snoozing) begin
               $error("snoozing exp %0b got %0b", e.snoozing, a.snoozing); errors++;
            end
         end
      end
   end

   // hold a button low for hold ticks then release
   task automatic press(int b, int hold);
      for (int i = 0; i < hold; i++) send_tick(~(8'd1 << b), 4'd0);
      send_tick(8'hFF, 4'd0);
   endtask

   // turn knob k one detent; up along reverse phase order
   task automatic turn(int k, bit up);
      logic [1:0] seq [4];
      seq = up ? '{2'd1, 2'd3, 2'd2, 2'd0} : '{2'd2, 2'd3, 2'd1, 2'd0};
      for (int i = 0; i < 4; i++) send_tick(8'hFF, 4'(seq[i]) << (2 * k));
   endtask

   task automatic test_directed();
      send_tick(8'h00, 4'hF);
      send_tick(8'hFF, 4'h0);
      press(BTN_SET_TIME, 12);
      turn(0, 1); turn(0, 0); turn(1, 1); turn(1, 0);
      send_tick(8'hFF, 4'h0);
      send_tick(8'hFF, 4'hA);   // step to an adjacent phase on both knobs counts as one step down
      send_tick(8'hFF, 4'h0);
      press(BTN_SET_ALARM, 12); // ignored while setting time
      press(BTN_SET_TIME, 12);
   endtask

   task automatic test_alarm_snooze();
      press(BTN_SET_ALARM, 12);
      turn(0, 1);
      press(BTN_SET_ALARM, 12);
      press(BTN_ARM, 12);
      press(BTN_TWELVE, 14);
      // run until the alarm sounds
      for (int i = 0; i < 140; i++) send_tick(8'hFF, 4'h0);
      press(BTN_SNOOZE, 12);
      for (int i = 0; i < 100; i++) send_tick(8'hFF, 4'h0);
      press(BTN_SOUND, 12);
      press(BTN_ARM, 12);
      press(BTN_TWELVE, 12);
   endtask

   task automatic test_random(int n);
      int b;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: send_tick(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            1: turn(int'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            default: begin
               b = $urandom_range(0, 7);
               press(b, $urandom_range(10, 14));
               i += 12;
            end
         endcase
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      idle_gaps = 1'b0;
      fork
         repeat (60) send_tick(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
         begin
            repeat (50) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      idle_gaps = 1'b1;
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      clock_reset_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_reg(CSR_TICKS, 16'd4);
      write_reg(CSR_SNOOZE, 16'd1);
      test_directed();
      drain();
      write_reg(CSR_TICKS, 16'd2);
      write_reg(CSR_SNOOZE, 16'd3);
      test_alarm_snooze();
      drain();
      write_reg(CSR_SNOOZE, 16'd255);
      test_random(100);
      drain();
      write_reg(CSR_TICKS, 16'd65535);
      write_reg(CSR_SNOOZE, 16'd10);
      test_backpressure();
      test_random(50);
      drain();
      write_reg(CSR_TICKS, 16'd3);
      test_random(100);
      drain();
      if (errors == 0 && expected_displays.size() == 0) begin
         $display("alarm_clock_controller_top test passed");
      end else begin
         $display("alarm_clock_controller_top test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("alarm_clock_controller_top test failed");
      $finish;
   end

endmodule
